/* hw/rtl/pit3d_pkg.sv */
// ----------------------------------------------------------------------------
// pit3d_pkg: shared types and constants for point_in_triangle_3d
// Register index codes and the index rotation used by the cross products.
// ----------------------------------------------------------------------------
package pit3d_pkg;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_POINT_X     = 2'd0,
		CFG_POINT_Y     = 2'd1,
		CFG_POINT_Z     = 2'd2,
		CFG_POINT_VALID = 2'd3
	} cfg_idx_t;

	// cross product component i uses u[NXT1[i]]*w[NXT2[i]] - u[NXT2[i]]*w[NXT1[i]]
	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

endpackage

/* hw/rtl/point_in_triangle_3d.sv */
// ----------------------------------------------------------------------------
// point_in_triangle_3d: query point versus triangle stream test
// Plane tolerance test in exact integer form and three same-side edge tests.
// ----------------------------------------------------------------------------
// Usage:
//  - the query point is set through the write port (cfg_we, cfg_idx, cfg_wdata)
//    while no triangle is in flight; index order is x, y, z, valid
//  - a triangle word is taken at each rising edge with start high and busy
//    low; busy is always low, so one triangle can be taken every cycle
//  - each triangle gives one result word: done is high for one cycle with
//    inside_res and off_plane valid, from the final compare stage; results
//    leave in the order the triangles came in
//  - throughput is one triangle per cycle; a triangle passes 11 register
//    stages: differences, cross products (multiply, subtract), dot products
//    (split multiply, recombine, sum), magnitude, limb products of the two
//    squared sides, two adder stages and the final compare
//  - the receiver cannot stall; a result is on the ports for that one cycle
//  - reset clears the query point, the valid flag and all stage valid bits;
//    no result word appears until a new triangle is started
//  - with no query point set both result fields are zero
// ----------------------------------------------------------------------------
module point_in_triangle_3d #(
	parameter int COORD_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [COORD_BITS-1:0]            a_x,
	input  logic signed [COORD_BITS-1:0]            a_y,
	input  logic signed [COORD_BITS-1:0]            a_z,
	input  logic signed [COORD_BITS-1:0]            b_x,
	input  logic signed [COORD_BITS-1:0]            b_y,
	input  logic signed [COORD_BITS-1:0]            b_z,
	input  logic signed [COORD_BITS-1:0]            c_x,
	input  logic signed [COORD_BITS-1:0]            c_y,
	input  logic signed [COORD_BITS-1:0]            c_z,
	input  logic                                    cfg_we,
	input  logic        [pit3d_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic        [COORD_BITS-1:0]            cfg_wdata,
	output logic                                    done,
	output logic                                    inside_res,
	output logic                                    off_plane
);

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;           // coordinate difference
	localparam int PW  = 2 * C + 2;       // difference product
	localparam int XW  = 2 * C + 3;       // cross product component
	localparam int H   = (XW + 1) / 2;    // low split of a cross component
	localparam int YHW = XW - H;          // high split of a cross component
	localparam int LOW = XW + H + 1;      // low partial product
	localparam int HIW = XW + YHW;        // high partial product
	localparam int QW  = 2 * XW;          // full cross by cross product
	localparam int NEW = XW + DW;         // normal times offset term
	localparam int EPW = 2 * DW;          // offset squared term
	localparam int DSW = 3 * C + 6;       // n.e
	localparam int NNW = 4 * C + 8;       // n.n
	localparam int EEW = 2 * C + 4;       // e.e
	localparam int SGW = QW + 2;          // edge dot product
	localparam int LW  = C + 2;           // limb of the wide squares
	localparam int DDW = 6 * LW;          // (n.e)^2 and (n.n)(e.e)
	localparam int LHW = DDW + 7;         // 100 (n.e)^2
	localparam int YW  = 4 * LW + 1;      // odd limb rows of (n.n)(e.e)

	// configuration registers
	logic signed [C-1:0] point_x_q, point_y_q, point_z_q;
	logic                point_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q     <= '0;
			point_y_q     <= '0;
			point_z_q     <= '0;
			point_valid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (pit3d_pkg::cfg_idx_t'(cfg_idx))
				pit3d_pkg::CFG_POINT_X:     point_x_q     <= $signed(cfg_wdata);
				pit3d_pkg::CFG_POINT_Y:     point_y_q     <= $signed(cfg_wdata);
				pit3d_pkg::CFG_POINT_Z:     point_z_q     <= $signed(cfg_wdata);
				pit3d_pkg::CFG_POINT_VALID: point_valid_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			v_s10  <= v_s9;
			done_q <= v_s10;
		end
	end

	// vertex and point vectors
	logic signed [C-1:0] va [3];
	logic signed [C-1:0] vb [3];
	logic signed [C-1:0] vc [3];
	logic signed [C-1:0] vp [3];

	always_comb begin
		va[0] = a_x; va[1] = a_y; va[2] = a_z;
		vb[0] = b_x; vb[1] = b_y; vb[2] = b_z;
		vc[0] = c_x; vc[1] = c_y; vc[2] = c_z;
		vp[0] = point_x_q; vp[1] = point_y_q; vp[2] = point_z_q;
	end

	// s1: edge and offset differences, one pair per cross product
	// pair 0 gives the normal, pairs 1..3 the point side of each edge
	logic signed [DW-1:0] u_s1 [4][3];
	logic signed [DW-1:0] w_s1 [4][3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s1[0][i] <= DW'(vb[i]) - DW'(va[i]);
			w_s1[0][i] <= DW'(vc[i]) - DW'(va[i]);
			u_s1[1][i] <= DW'(vb[i]) - DW'(va[i]);
			w_s1[1][i] <= DW'(vp[i]) - DW'(va[i]);
			u_s1[2][i] <= DW'(vc[i]) - DW'(vb[i]);
			w_s1[2][i] <= DW'(vp[i]) - DW'(vb[i]);
			u_s1[3][i] <= DW'(va[i]) - DW'(vc[i]);
			w_s1[3][i] <= DW'(vp[i]) - DW'(vc[i]);
		end
	end

	// s2: cross product terms
	logic signed [PW-1:0] pa_s2 [4][3];
	logic signed [PW-1:0] pb_s2 [4][3];
	logic signed [DW-1:0] e2_s2 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[k][i] <= u_s1[k][pit3d_pkg::NXT1[i]] * w_s1[k][pit3d_pkg::NXT2[i]];
				pb_s2[k][i] <= u_s1[k][pit3d_pkg::NXT2[i]] * w_s1[k][pit3d_pkg::NXT1[i]];
			end
		end
		for (int i = 0; i < 3; i++) begin
			e2_s2[i] <= w_s1[1][i];
		end
	end

	// s3: cross product components
	logic signed [XW-1:0] x_s3 [4][3];
	logic signed [DW-1:0] e2_s3 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				x_s3[k][i] <= XW'(pa_s2[k][i]) - XW'(pb_s2[k][i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			e2_s3[i] <= e2_s2[i];
		end
	end

	// s4: dot product terms; normal times cross component is split in two halves
	logic signed [LOW-1:0] lo_s4 [4][3];
	logic signed [HIW-1:0] hi_s4 [4][3];
	logic signed [NEW-1:0] nep_s4 [3];
	logic signed [EPW-1:0] eep_s4 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				lo_s4[k][i] <= x_s3[0][i] * $signed({1'b0, x_s3[k][i][H-1:0]});
				hi_s4[k][i] <= x_s3[0][i] * $signed(x_s3[k][i][XW-1:H]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			nep_s4[i] <= x_s3[0][i] * e2_s3[i];
			eep_s4[i] <= e2_s3[i] * e2_s3[i];
		end
	end

	// s5: recombine split products
	logic signed [QW-1:0]  q_s5 [4][3];
	logic signed [NEW-1:0] nep_s5 [3];
	logic signed [EPW-1:0] eep_s5 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				q_s5[k][i] <= $signed({hi_s4[k][i], {H{1'b0}}}) + QW'(lo_s4[k][i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			nep_s5[i] <= nep_s4[i];
			eep_s5[i] <= eep_s4[i];
		end
	end

	// s6: dot product sums; an edge passes when its dot product is not negative
	logic signed [SGW-1:0] dot_sum [3];
	logic signed [DSW-1:0] d_s6;
	logic signed [NNW-1:0] nn_s6;
	logic signed [EEW-1:0] ee_s6;
	logic        [2:0]     edge_ok_s6;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dot_sum[j] = SGW'(q_s5[j+1][0]) + SGW'(q_s5[j+1][1]) + SGW'(q_s5[j+1][2]);
		end
	end

	always_ff @(posedge clk) begin
		d_s6  <= DSW'(nep_s5[0]) + DSW'(nep_s5[1]) + DSW'(nep_s5[2]);
		nn_s6 <= NNW'(q_s5[0][0]) + NNW'(q_s5[0][1]) + NNW'(q_s5[0][2]);
		ee_s6 <= EEW'(eep_s5[0]) + EEW'(eep_s5[1]) + EEW'(eep_s5[2]);
		for (int j = 0; j < 3; j++) begin
			edge_ok_s6[j] <= !dot_sum[j][SGW-1];
		end
	end

	// s7: magnitude of n.e; n.n and e.e are never negative
	logic [DSW-1:0] dabs_s7;
	logic [NNW-1:0] nn_s7;
	logic [EEW-1:0] ee_s7;
	logic [2:0]     edge_ok_s7;

	always_ff @(posedge clk) begin
		dabs_s7    <= d_s6[DSW-1] ? $unsigned(-d_s6) : $unsigned(d_s6);
		nn_s7      <= $unsigned(nn_s6);
		ee_s7      <= $unsigned(ee_s6);
		edge_ok_s7 <= edge_ok_s6;
	end

	// s8: limb products of (n.e)^2 (symmetric terms once) and (n.n)(e.e)
	logic [2*LW-1:0] dd00_s8, dd11_s8, dd22_s8, dd01_s8, dd12_s8, dd02_s8;
	logic [2*LW-1:0] npp_s8 [4][2];
	logic [2:0]      edge_ok_s8;

	always_ff @(posedge clk) begin
		dd00_s8 <= dabs_s7[0 +: LW] * dabs_s7[0 +: LW];
		dd11_s8 <= dabs_s7[LW +: LW] * dabs_s7[LW +: LW];
		dd22_s8 <= dabs_s7[2*LW +: LW] * dabs_s7[2*LW +: LW];
		dd01_s8 <= dabs_s7[0 +: LW] * dabs_s7[LW +: LW];
		dd12_s8 <= dabs_s7[LW +: LW] * dabs_s7[2*LW +: LW];
		dd02_s8 <= dabs_s7[0 +: LW] * dabs_s7[2*LW +: LW];
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 2; j++) begin
				npp_s8[i][j] <= nn_s7[i*LW +: LW] * ee_s7[j*LW +: LW];
			end
		end
		edge_ok_s8 <= edge_ok_s7;
	end

	// s9: limb rows; products that do not overlap are packed side by side
	logic [DDW-1:0] dd_s9;
	logic [DDW-1:0] xs_s9;
	logic [YW-1:0]  ys_s9;
	logic [2:0]     edge_ok_s9;

	always_ff @(posedge clk) begin
		dd_s9 <= {dd22_s8, dd11_s8, dd00_s8}
			+ (DDW'({dd12_s8, dd01_s8}) << (LW + 1))
			+ (DDW'(dd02_s8) << (2 * LW + 1));
		xs_s9 <= {npp_s8[3][1], npp_s8[2][0], npp_s8[0][0]}
			+ (DDW'(npp_s8[1][1]) << (2 * LW));
		ys_s9 <= YW'({npp_s8[3][0], npp_s8[1][0]}) + YW'({npp_s8[2][1], npp_s8[0][1]});
		edge_ok_s9 <= edge_ok_s8;
	end

	// s10: 100 (n.e)^2 as 64 + 32 + 4 times, and the full (n.n)(e.e)
	logic [LHW-1:0] lhs_s10;
	logic [DDW-1:0] rhs_s10;
	logic [2:0]     edge_ok_s10;

	always_ff @(posedge clk) begin
		lhs_s10 <= (LHW'(dd_s9) << 6) + (LHW'(dd_s9) << 5) + (LHW'(dd_s9) << 2);
		rhs_s10 <= xs_s9 + (DDW'(ys_s9) << LW);
		edge_ok_s10 <= edge_ok_s9;
	end

	// result word; user, not block, must hold query point while triangles in flight
	logic far_plane;
	logic inside_q, off_plane_q;

	assign far_plane = lhs_s10 > LHW'(rhs_s10);

	always_ff @(posedge clk) begin
		off_plane_q <= point_valid_q && far_plane;
		inside_q    <= point_valid_q && !far_plane && (&edge_ok_s10);
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign off_plane  = off_plane_q;

`ifndef SYNTH
	// every result word comes from a matching earlier triangle start
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 11))
		else $error("result word without a matching start");

	// a point rejected by the plane test is never reported inside
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(inside_res && off_plane))
		else $error("inside and off plane both set");

	// no query point gives an all-zero result word
	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		done && !point_valid_q |-> !inside_res && !off_plane)
		else $error("result set without a query point");

	// a degenerate triangle (zero normal) passes every edge test
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && (nn_s7 == '0) |-> (edge_ok_s7 == 3'b111))
		else $error("zero normal failed an edge test");
`endif

endmodule
